[sv/msfg_pkg.sv]
`timescale 1ns / 1ps

package msfg_pkg;

  // Command codes
  localparam logic [2:0] CMD_REMOTE  = 3'd0;
  localparam logic [2:0] CMD_LOCAL   = 3'd1;
  localparam logic [2:0] CMD_OUT_ON  = 3'd2;
  localparam logic [2:0] CMD_OUT_OFF = 3'd3;
  localparam logic [2:0] CMD_SET_V   = 3'd4;
  localparam logic [2:0] CMD_SET_I   = 3'd5;

  localparam int unsigned IDX_W = 4;

  localparam logic [IDX_W-1:0] REMOTE_LEN = 4'd13;
  localparam logic [IDX_W-1:0] LOCAL_LEN  = 4'd12;
  localparam logic [IDX_W-1:0] FRAME_LEN  = 4'd11;
  localparam logic [IDX_W-1:0] CRC_SPAN   = 4'd9;
  localparam logic [IDX_W-1:0] IDX_REG    = 4'd3;
  localparam logic [IDX_W-1:0] IDX_VAL_HI = 4'd7;
  localparam logic [IDX_W-1:0] IDX_VAL_LO = 4'd8;
  localparam logic [IDX_W-1:0] IDX_CRC_HI = 4'd9;
  localparam logic [IDX_W-1:0] IDX_CRC_LO = 4'd10;
  localparam logic [IDX_W-1:0] HDR_LEN    = 4'd7;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] SCALE_V  = 16'd100;
  localparam logic [15:0] SCALE_I  = 16'd1000;

  localparam logic [7:0] REMOTE_TEXT [13] = '{
    8'h53, 8'h59, 8'h53, 8'h54, 8'h3A, 8'h52, 8'h45, 8'h4D, 8'h4F, 8'h54, 8'h45,
    8'h0D, 8'h0A
  };

  localparam logic [7:0] LOCAL_TEXT [12] = '{
    8'h53, 8'h59, 8'h53, 8'h54, 8'h3A, 8'h4C, 8'h4F, 8'h43, 8'h41, 8'h4C,
    8'h0D, 8'h0A
  };

  localparam logic [7:0] POWER_FRAME [11] = '{
    8'h00, 8'h10, 8'h10, 8'h04, 8'h00, 8'h01, 8'h02, 8'h00, 8'h01, 8'h7A, 8'h45
  };

  localparam logic [7:0] FRAME_HDR [7] = '{
    8'h00, 8'h10, 8'h10, 8'h00, 8'h00, 8'h01, 8'h02
  };

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic             capture;
    logic             load;
    logic             last;
    logic [2:0]       cmd;
    logic [IDX_W-1:0] idx;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } dp_sts_t;

  function automatic logic [IDX_W-1:0] msg_len(input logic [2:0] cmd);
    logic [IDX_W-1:0] n;
    case (cmd)
      CMD_REMOTE:  n = REMOTE_LEN;
      CMD_LOCAL:   n = LOCAL_LEN;
      CMD_OUT_ON,
      CMD_OUT_OFF,
      CMD_SET_V,
      CMD_SET_I:   n = FRAME_LEN;
      default:     n = '0;
    endcase
    return n;
  endfunction

  function automatic logic is_set_cmd(input logic [2:0] cmd);
    return (cmd == CMD_SET_V) || (cmd == CMD_SET_I);
  endfunction

  // One byte of CRC-16/Modbus, reflected
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] msg_byte(input logic [2:0] cmd, input logic [IDX_W-1:0] idx,
                                          input logic [15:0] scaled, input logic [15:0] crc);
    logic [7:0] b;
    b = 8'h00;
    case (cmd)
      CMD_REMOTE: begin
        if (idx < REMOTE_LEN) b = REMOTE_TEXT[idx];
      end
      CMD_LOCAL: begin
        if (idx < LOCAL_LEN) b = LOCAL_TEXT[idx];
      end
      CMD_OUT_ON, CMD_OUT_OFF: begin
        if (idx < FRAME_LEN) b = POWER_FRAME[idx];
      end
      CMD_SET_V, CMD_SET_I: begin
        if (idx == IDX_REG) b = {7'd0, cmd == CMD_SET_I};
        else if (idx < HDR_LEN) b = FRAME_HDR[idx[2:0]];
        else if (idx == IDX_VAL_HI) b = scaled[15:8];
        else if (idx == IDX_VAL_LO) b = scaled[7:0];
        else if (idx == IDX_CRC_HI) b = crc[15:8];
        else if (idx == IDX_CRC_LO) b = crc[7:0];
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

[sv/msfg_dp.sv]
`timescale 1ns / 1ps

module msfg_dp import msfg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     ctl_i,
  output dp_sts_t     sts_o,
  input  logic [15:0] set_value_i,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output logic [7:0]  tx_byte_o,
  output logic        last_byte_o
);

  logic        out_valid_q, out_valid_d;
  logic [7:0]  tx_byte_q;
  logic        last_q;
  logic [15:0] scaled_q, scaled_d;
  logic [15:0] crc_q;
  logic [7:0]  byte_d;
  logic        crc_upd;

  // Scaled setting wraps to 16 bits
  assign scaled_d = set_value_i * ((ctl_i.cmd == CMD_SET_I) ? SCALE_I : SCALE_V);
  assign byte_d   = msg_byte(ctl_i.cmd, ctl_i.idx, scaled_q, crc_q);
  assign crc_upd  = ctl_i.load && is_set_cmd(ctl_i.cmd) && (ctl_i.idx < CRC_SPAN);

  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_i.load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      scaled_q <= scaled_d;
      crc_q    <= CRC_INIT;
    end else if (crc_upd) begin
      crc_q <= crc_step(crc_q, byte_d);
    end
    if (ctl_i.load) begin
      tx_byte_q <= byte_d;
      last_q    <= ctl_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign tx_byte_o   = tx_byte_q;
  assign last_byte_o = last_q;

  a_crc_seed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.capture |=> crc_q == CRC_INIT)
    else $error("crc not seeded on capture");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.load |=> out_valid_q)
    else $error("loaded word not presented");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.load |-> (!out_valid_q || !out_stall_i))
    else $error("held word overwritten");

endmodule

[sv/msfg_ctrl.sv]
`timescale 1ns / 1ps

module msfg_ctrl import msfg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] command_i,
  input  dp_sts_t    sts_i,
  output dp_cmd_t    ctl_o
);

  state_e           state_q, state_d;
  logic [2:0]       cmd_q, cmd_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             accept;
  logic             is_last;

  assign accept  = in_valid_i && (state_q == ST_IDLE);
  assign is_last = (idx_q == msg_len(cmd_q) - 1'b1);

  // Next state
  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    idx_d   = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_d = command_i;
          idx_d = '0;
          // Drop unknown commands: nothing to send
          if (msg_len(command_i) != '0) state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          idx_d = idx_q + 1'b1;
          if (is_last) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall_o    = 1'b1;
    ctl_o.capture = 1'b0;
    ctl_o.load    = 1'b0;
    ctl_o.last    = is_last;
    ctl_o.cmd     = cmd_q;
    ctl_o.idx     = idx_q;
    case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        ctl_o.capture = accept;
        ctl_o.cmd     = command_i;
      end
      ST_EMIT: begin
        ctl_o.load = sts_i.out_free;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cmd_q   <= CMD_REMOTE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
      idx_q   <= idx_d;
    end
  end

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> idx_q < msg_len(cmd_q))
    else $error("byte index past end of message");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.load && ctl_o.last |=> state_q == ST_IDLE)
    else $error("no return to idle after last byte");

  a_known_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> msg_len(cmd_q) != '0)
    else $error("emitting for an unknown command");

endmodule

[sv/modbus_setpoint_frame_generator.sv]
`timescale 1ns / 1ps

// Channel | Handshake             | Payload
// --------+-----------------------+----------------------------------
// in      | in_valid_i/in_stall_o | command_i[2:0], set_value_i[15:0]
// out     | out_valid_o/out_stall_i | tx_byte_o[7:0], last_byte_o
//
// A command sends N bytes, N being 13 (remote), 12 (local) or 11 (frames);
// an unknown command sends nothing. The byte sequencer loads one word per
// cycle into the output register while the output is not stalled, and
// updates the CRC one byte per cycle over the set-frame bytes it covers.
// Reset clears the sequencer and output valid; the input is taken right after.
// An output stall holds the word and pauses the sequencer.

module modbus_setpoint_frame_generator import msfg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [15:0] set_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  tx_byte_o,
  output logic        last_byte_o
);

  dp_cmd_t ctl;
  dp_sts_t sts;

  msfg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  msfg_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .set_value_i (set_value_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .tx_byte_o   (tx_byte_o),
    .last_byte_o (last_byte_o)
  );

endmodule

[test/tb_modbus_setpoint_frame_generator.sv]
`timescale 1ns / 1ps

module tb_modbus_setpoint_frame_generator;
  import msfg_pkg::*;

  localparam logic [2:0]  CMD_SPARE_6  = 3'd6;
  localparam logic [2:0]  CMD_SPARE_7  = 3'd7;
  localparam logic [7:0]  ASCII_CR     = 8'h0D;
  localparam logic [7:0]  ASCII_LF     = 8'h0A;
  localparam logic [15:0] MB_CRC_SEED  = 16'hFFFF;
  localparam logic [15:0] MB_CRC_POLY  = 16'hA001;
  localparam logic [15:0] VOLT_SCALE   = 16'd100;
  localparam logic [15:0] AMP_SCALE    = 16'd1000;
  localparam logic [7:0]  PWR_WORDS [11] = '{
    8'h00, 8'h10, 8'h10, 8'h04, 8'h00, 8'h01, 8'h02, 8'h00, 8'h01, 8'h7A, 8'h45
  };
  localparam int RUN_LIMIT_NS = 5_000_000;
  localparam int DRAIN_LIMIT  = 20_000;

  typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_e;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } tx_word_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [2:0]  command_i   = '0;
  logic [15:0] set_value_i = '0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [7:0]  tx_byte_o;
  logic        last_byte_o;

  tx_word_t tx_expect [$];
  int       cmd_count [8];
  int       mismatches    = 0;
  int       words_checked = 0;
  int       seqs_checked  = 0;
  int       intake_stalls = 0;
  int       burst_left    = 0;
  int       hold_left     = 0;
  int       rx_phase      = 0;
  bit       sender_gaps   = 1'b1;
  rx_mode_e rx_mode       = RX_LIGHT;

  modbus_setpoint_frame_generator u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .set_value_i(set_value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .tx_byte_o  (tx_byte_o),
    .last_byte_o(last_byte_o)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #(RUN_LIMIT_NS);
    $display("TB_ERROR");
    $finish;
  end

  // Queue an ASCII command string; CR LF closes it
  function automatic void push_text(input string body);
    for (int k = 0; k < body.len(); k++) begin
      tx_expect.push_back('{body[k], 1'b0});
    end
    tx_expect.push_back('{ASCII_CR, 1'b0});
    tx_expect.push_back('{ASCII_LF, 1'b1});
  endfunction

  // Queue the byte sequence that one command must produce
  function automatic void expect_command(input logic [2:0] cmd, input logic [15:0] val);
    logic [7:0]  frame [11];
    logic [15:0] scaled;
    logic [15:0] crc;
    case (cmd)
      CMD_REMOTE: push_text("SYST:REMOTE");
      CMD_LOCAL:  push_text("SYST:LOCAL");
      CMD_OUT_ON, CMD_OUT_OFF: begin
        for (int k = 0; k < 11; k++) begin
          tx_expect.push_back('{PWR_WORDS[k], k == 10});
        end
      end
      CMD_SET_V, CMD_SET_I: begin
        // product wraps to 16 bits
        scaled = (cmd == CMD_SET_V) ? val * VOLT_SCALE : val * AMP_SCALE;
        frame = '{8'h00, 8'h10, 8'h10, {7'd0, cmd == CMD_SET_I}, 8'h00, 8'h01, 8'h02,
                  scaled[15:8], scaled[7:0], 8'h00, 8'h00};
        crc = MB_CRC_SEED;
        for (int k = 0; k < 9; k++) begin
          crc ^= {8'h00, frame[k]};
          for (int b = 0; b < 8; b++) begin
            crc = crc[0] ? ((crc >> 1) ^ MB_CRC_POLY) : (crc >> 1);
          end
        end
        // high byte of the CRC goes first
        frame[9]  = crc[15:8];
        frame[10] = crc[7:0];
        for (int k = 0; k < 11; k++) begin
          tx_expect.push_back('{frame[k], k == 10});
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [2:0] random_command();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return ($urandom_range(0, 1) == 0) ? CMD_SPARE_6 : CMD_SPARE_7;
    if (r < 50) return ($urandom_range(0, 1) == 0) ? CMD_SET_V : CMD_SET_I;
    return 3'($urandom_range(0, 3));
  endfunction

  function automatic logic [15:0] random_setting();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(50, 700));
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one word and wait until it is taken; valid stays high inside a burst
  task automatic send_command(input logic [2:0] cmd, input logic [15:0] val);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap = sender_gaps ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i  <= 1'b0;
        command_i   <= 3'($urandom);
        set_value_i <= 16'($urandom);
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    set_value_i <= val;
    do @(posedge clk_i); while (in_stall_o);
    expect_command(cmd, val);
    cmd_count[cmd]++;
  endtask

  task automatic send_random(input int count);
    for (int n = 0; n < count; n++) begin
      send_command(random_command(), random_setting());
    end
  endtask

  task automatic test_directed_edges();
    rx_mode = RX_LIGHT;
    sender_gaps = 1'b1;
    send_command(CMD_REMOTE, 16'h0000);
    send_command(CMD_LOCAL, 16'hFFFF);
    send_command(CMD_OUT_ON, 16'h1234);
    send_command(CMD_OUT_OFF, 16'h0000);
    send_command(CMD_SET_V, 16'h0000);
    send_command(CMD_SET_V, 16'h0001);
    send_command(CMD_SET_V, 16'd655);
    send_command(CMD_SET_V, 16'd656);
    send_command(CMD_SET_V, 16'hFFFF);
    send_command(CMD_SET_V, 16'h8000);
    send_command(CMD_SET_V, 16'h5555);
    send_command(CMD_SET_I, 16'h0000);
    send_command(CMD_SET_I, 16'h0001);
    send_command(CMD_SET_I, 16'd65);
    send_command(CMD_SET_I, 16'd66);
    send_command(CMD_SET_I, 16'hFFFF);
    send_command(CMD_SET_I, 16'hAAAA);
    send_command(CMD_SPARE_6, 16'hFFFF);
    send_command(CMD_SPARE_7, 16'h0000);
    send_command(CMD_SET_V, 16'h0100);
    // setting must not matter for the fixed sequences
    send_command(CMD_REMOTE, 16'hFFFF);
    send_command(CMD_LOCAL, 16'h0000);
    send_command(CMD_OUT_ON, 16'hFFFF);
    send_command(CMD_OUT_OFF, 16'h00FF);
  endtask

  task automatic test_random_traffic();
    rx_mode = RX_LIGHT;
    sender_gaps = 1'b1;
    send_random(150);
  endtask

  task automatic test_back_to_back();
    rx_mode = RX_FREE;
    sender_gaps = 1'b0;
    send_random(60);
    sender_gaps = 1'b1;
  endtask

  task automatic test_long_hold();
    rx_mode = RX_FREE;
    sender_gaps = 1'b0;
    hold_left = 300;
    send_random(30);
    sender_gaps = 1'b1;
  endtask

  task automatic test_heavy_stall();
    rx_mode = RX_HEAVY;
    sender_gaps = 1'b1;
    send_random(60);
  endtask

  task automatic test_periodic_stall();
    rx_mode = RX_PERIODIC;
    sender_gaps = 1'b1;
    send_random(60);
  endtask

  // Receiver pacing; a pending hold-off overrides the pattern
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      case (rx_mode)
        RX_FREE:     out_stall_i <= 1'b0;
        RX_LIGHT:    out_stall_i <= ($urandom_range(0, 3) == 0);
        RX_HEAVY:    out_stall_i <= ($urandom_range(0, 9) < 7);
        RX_PERIODIC: out_stall_i <= ((rx_phase % 7) < 3);
        default:     out_stall_i <= 1'b0;
      endcase
    end
    rx_phase++;
  end

  always @(posedge clk_i) begin : check_output
    tx_word_t want;
    if (rst_ni) begin
      if (in_valid_i && in_stall_o) intake_stalls++;
      if ($isunknown(out_valid_o)) begin
        $error("out_valid_o is unknown");
        mismatches++;
      end else if (out_valid_o && !out_stall_i) begin
        if (tx_expect.size() == 0) begin
          $error("unexpected word: tx_byte %h last_byte %b", tx_byte_o, last_byte_o);
          mismatches++;
        end else begin
          want = tx_expect.pop_front();
          if (tx_byte_o !== want.data) begin
            $error("tx_byte: expected %h, got %h", want.data, tx_byte_o);
            mismatches++;
          end
          if (last_byte_o !== want.last) begin
            $error("last_byte: expected %b, got %b", want.last, last_byte_o);
            mismatches++;
          end
          words_checked++;
          if (want.last) seqs_checked++;
        end
      end
    end
  end

  initial begin : main_seq
    int waited;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_edges();
    test_random_traffic();
    test_back_to_back();
    test_long_hold();
    test_heavy_stall();
    test_periodic_stall();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    rx_mode = RX_LIGHT;

    waited = 0;
    while (tx_expect.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (tx_expect.size() != 0) begin
      $error("%0d expected words never arrived", tx_expect.size());
      mismatches++;
    end
    repeat (30) @(posedge clk_i);

    $display("commands by code 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
             cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3],
             cmd_count[4], cmd_count[5], cmd_count[6], cmd_count[7]);
    $display("%0d bytes in %0d sequences compared, input held back on %0d cycles",
             words_checked, seqs_checked, intake_stalls);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
